@@ src/arlt_pkg.sv @@
// Shared types and codes for the address range lock table.
package arlt_pkg;

  localparam int unsigned FIELD_ADDR_W = 32;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned SLOT_W       = 5;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  localparam status_t ST_GRANTED   = 3'd0;
  localparam status_t ST_CONFLICT  = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_RELEASED  = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

endpackage

@@ src/arlt_mem.sv @@
// Entry storage: base and length of each lock, one write port and one registered read port.
module arlt_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 32,
  parameter int unsigned IW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [AW-1:0] wbase_i,
  input  logic [AW-1:0] wlen_i,
  input  logic [IW-1:0] raddr_i,
  output logic [AW-1:0] rbase_o,
  output logic [AW-1:0] rlen_o
);

  logic [AW-1:0] base_mem [DEPTH];
  logic [AW-1:0] len_mem  [DEPTH];
  logic [AW-1:0] rbase_q;
  logic [AW-1:0] rlen_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      base_mem[waddr_i] <= wbase_i;
      len_mem[waddr_i]  <= wlen_i;
    end
    rbase_q <= base_mem[raddr_i];
    rlen_q  <= len_mem[raddr_i];
  end

  assign rbase_o = rbase_q;
  assign rlen_o  = rlen_q;

endmodule

@@ src/arlt_cmp.sv @@
// Range overlap compare unit: [ea, ea+el) against [b, b+l) without forming any sum.
module arlt_cmp #(
  parameter int unsigned AW = 32
) (
  input  logic [AW-1:0] entry_base_i,
  input  logic [AW-1:0] entry_len_i,
  input  logic [AW-1:0] req_base_i,
  input  logic [AW-1:0] req_len_i,
  output logic          overlap_o
);

  logic starts_before_end;
  logic ends_after_start;

  always_comb begin
    starts_before_end = (entry_base_i < req_base_i) ||
                        ((entry_base_i - req_base_i) < req_len_i);
    ends_after_start  = (entry_base_i > req_base_i) ||
                        ((req_base_i - entry_base_i) < entry_len_i);
    overlap_o = starts_before_end && ends_after_start;
  end

endmodule

@@ src/address_range_lock_table.sv @@
// Top level: request latch, scan sequencer, valid bits and result register.
// The scan reads one entry per cycle from the entry memory into the compare unit.
// A conflict or a matching release ends the scan early at the first overlapping entry.
// No new request is taken while a scan runs or its result waits on an output stall;
//   the next request is taken once the result is registered.
// Reset clears all valid bits and control state at once; entry memory needs no clearing.
module address_range_lock_table #(
  parameter int unsigned POOL_ENTRIES = 32,
  parameter int unsigned ADDR_WIDTH   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [31:0]           base_addr_i,
  input  logic [31:0]           range_len_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output arlt_pkg::status_t     status_o,
  output arlt_pkg::slot_t       slot_o
);

  import arlt_pkg::*;

  localparam int unsigned IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_ENTRIES - 1);
  localparam logic [ADDR_WIDTH-1:0] ONE_LEN = ADDR_WIDTH'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]              state_q, state_d;
  logic                    mode_q, mode_d;
  logic [ADDR_WIDTH-1:0]   base_q, base_d;
  logic [ADDR_WIDTH-1:0]   len_q, len_d;
  logic [IW-1:0]           rd_idx_q, rd_idx_d;
  logic [IW-1:0]           cmp_idx_q, cmp_idx_d;
  logic                    cmp_vld_q, cmp_vld_d;
  logic                    hit_q, hit_d;
  logic [IW-1:0]           hit_idx_q, hit_idx_d;
  logic                    free_found_q, free_found_d;
  logic [IW-1:0]           free_idx_q, free_idx_d;
  logic [POOL_ENTRIES-1:0] vbits_q, vbits_d;
  logic                    out_valid_q, out_valid_d;
  status_t                 status_q, status_d;
  logic [IW-1:0]           slot_idx_q, slot_idx_d;

  logic [ADDR_WIDTH-1:0]   in_base;
  logic [ADDR_WIDTH-1:0]   in_len;
  logic [ADDR_WIDTH-1:0]   rd_base;
  logic [ADDR_WIDTH-1:0]   rd_len;
  logic                    overlap;
  logic                    cur_valid;
  logic                    accept;
  logic                    done_adv;
  logic                    mem_we;

  // Cut or zero-extend the request fields to the address width.
  for (genvar k = 0; k < ADDR_WIDTH; k++) begin : g_addr
    if (k < FIELD_ADDR_W) begin : g_bit
      assign in_base[k] = base_addr_i[k];
      assign in_len[k]  = range_len_i[k];
    end else begin : g_zero
      assign in_base[k] = 1'b0;
      assign in_len[k]  = 1'b0;
    end
  end

  // Slot index is cut or zero-extended into the slot field.
  for (genvar k = 0; k < SLOT_W; k++) begin : g_slot
    if (k < IW) begin : g_bit
      assign slot_o[k] = slot_idx_q[k];
    end else begin : g_zero
      assign slot_o[k] = 1'b0;
    end
  end

  arlt_mem #(
    .DEPTH (POOL_ENTRIES),
    .AW    (ADDR_WIDTH),
    .IW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (free_idx_q),
    .wbase_i (base_q),
    .wlen_i  (len_q),
    .raddr_i (rd_idx_q),
    .rbase_o (rd_base),
    .rlen_o  (rd_len)
  );

  arlt_cmp #(
    .AW (ADDR_WIDTH)
  ) u_cmp (
    .entry_base_i (rd_base),
    .entry_len_i  (rd_len),
    .req_base_i   (base_q),
    .req_len_i    (len_q),
    .overlap_o    (overlap)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cur_valid   = vbits_q[cmp_idx_q];
  assign done_adv    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign mem_we      = done_adv && (mode_q == MODE_ACQUIRE) && !hit_q && free_found_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    base_d       = base_q;
    len_d        = len_q;
    rd_idx_d     = rd_idx_q;
    cmp_idx_d    = cmp_idx_q;
    cmp_vld_d    = cmp_vld_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    vbits_d      = vbits_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    slot_idx_d   = slot_idx_q;

    // Drop the result beat once taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d       = mode_i;
          base_d       = in_base;
          len_d        = (mode_i == MODE_RELEASE) ? ONE_LEN : in_len;
          rd_idx_d     = '0;
          cmp_idx_d    = '0;
          cmp_vld_d    = 1'b0;
          hit_d        = 1'b0;
          hit_idx_d    = '0;
          free_found_d = 1'b0;
          free_idx_d   = '0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue the next read; compare the entry read last cycle.
        cmp_vld_d = 1'b1;
        cmp_idx_d = rd_idx_q;
        if (rd_idx_q != LAST_IDX) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (cmp_vld_q) begin
          if (!cur_valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = cmp_idx_q;
          end
          if (cur_valid && overlap) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
            state_d   = S_DONE;
          end else if (cmp_idx_q == LAST_IDX) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (done_adv) begin
          out_valid_d = 1'b1;
          slot_idx_d  = '0;
          if (mode_q == MODE_ACQUIRE) begin
            if (hit_q) begin
              status_d   = ST_CONFLICT;
              slot_idx_d = hit_idx_q;
            end else if (free_found_q) begin
              status_d            = ST_GRANTED;
              slot_idx_d          = free_idx_q;
              vbits_d[free_idx_q] = 1'b1;
            end else begin
              status_d = ST_FULL;
            end
          end else begin
            if (hit_q) begin
              status_d           = ST_RELEASED;
              slot_idx_d         = hit_idx_q;
              vbits_d[hit_idx_q] = 1'b0;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      vbits_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmp_vld_q    <= cmp_vld_d;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      vbits_q      <= vbits_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    base_q     <= base_d;
    len_q      <= len_d;
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    status_q   <= status_d;
    slot_idx_q <= slot_idx_d;
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("request taken without starting a scan");

  a_grant_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> vbits_q[$past(free_idx_q)])
    else $error("granted slot not marked valid");

  a_release_clears_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_adv && (mode_q == MODE_RELEASE) && hit_q) |=> !vbits_q[$past(hit_idx_q)])
    else $error("released slot still valid");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_NOT_FOUND))
    else $error("result status out of range");

  a_hit_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && (state_d == S_DONE) && hit_d) |-> cur_valid)
    else $error("scan hit on an entry that holds no lock");

endmodule
